// ===== hw/rtl/ien_pkg.sv =====
`timescale 1ns / 1ps

package ien_pkg;

    // Default depth of the queue between the front and back parts
    localparam int QUEUE_DEPTH_DEF = 2;

    // Most results one input character can cause
    localparam int MAX_RESULTS = 4;
    localparam int SLOT_W      = $clog2(MAX_RESULTS);

    localparam logic [7:0] ASCII_NUL    = 8'h00;
    localparam logic [7:0] ASCII_TAB    = 8'h09;
    localparam logic [7:0] ASCII_CR     = 8'h0D;
    localparam logic [7:0] ASCII_SPACE  = 8'h20;
    localparam logic [7:0] ASCII_LPAREN = 8'h28;
    localparam logic [7:0] ASCII_RPAREN = 8'h29;
    localparam logic [7:0] ASCII_STAR   = 8'h2A;
    localparam logic [7:0] ASCII_MINUS  = 8'h2D;
    localparam logic [7:0] ASCII_ZERO   = 8'h30;
    localparam logic [7:0] ASCII_NINE   = 8'h39;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_ch;
        logic       out_last;
    } t_out_item;

    // Expansion of one input character: up to four result characters
    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] chars;
        logic [SLOT_W-1:0]           cnt_m1;
        logic                        last;
    } t_bundle;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= ASCII_ZERO) && (c <= ASCII_NINE);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == ASCII_SPACE) || ((c >= ASCII_TAB) && (c <= ASCII_CR));
    endfunction

endpackage

// ===== hw/rtl/ien_front.sv =====
`timescale 1ns / 1ps

module ien_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ien_pkg::t_in_item i_in_data,
    input  logic              i_q_full,
    output logic              o_push,
    output ien_pkg::t_bundle  o_bundle
);
    import ien_pkg::*;

    logic [7:0] r_prev;
    logic       r_have;
    logic       r_neg;
    logic [7:0] n_prev;
    logic       n_have;
    logic       n_neg;
    logic       accept;
    logic [2:0] cnt;
    t_bundle    bundle;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && !i_q_full;

    always_comb begin
        logic       star;
        logic [7:0] c;
        c      = i_in_data.ch;
        star   = 1'b0;
        n_prev = r_prev;
        n_have = r_have;
        n_neg  = r_neg;
        cnt    = 3'd0;
        bundle = '0;
        if (!is_space(c)) begin
            star = r_have && (r_prev == ASCII_RPAREN) && (c == ASCII_LPAREN);
            // Close an open unary minus on the first non-digit
            if (r_neg && !is_digit(c)) begin
                bundle.chars[cnt[1:0]] = ASCII_RPAREN;
                cnt    = cnt + 3'd1;
                n_prev = ASCII_RPAREN;
                n_neg  = 1'b0;
            end
            if (star) begin
                bundle.chars[cnt[1:0]] = ASCII_STAR;
                cnt = cnt + 3'd1;
            end
            if ((c == ASCII_MINUS) &&
                (!r_have || ((n_prev != ASCII_RPAREN) && !is_digit(n_prev)))) begin
                bundle.chars[cnt[1:0]] = ASCII_LPAREN;
                cnt = cnt + 3'd1;
                bundle.chars[cnt[1:0]] = ASCII_ZERO;
                cnt = cnt + 3'd1;
                bundle.chars[cnt[1:0]] = ASCII_MINUS;
                cnt    = cnt + 3'd1;
                n_prev = ASCII_MINUS;
                n_neg  = 1'b1;
            end else begin
                bundle.chars[cnt[1:0]] = c;
                cnt    = cnt + 3'd1;
                n_prev = c;
            end
            n_have = 1'b1;
        end
        if (i_in_data.last) begin
            if (n_neg) begin
                bundle.chars[cnt[1:0]] = ASCII_RPAREN;
                cnt = cnt + 3'd1;
            end
            if (cnt == 3'd0) begin
                bundle.chars[0] = ASCII_NUL;
                cnt = 3'd1;
            end
            bundle.last = 1'b1;
            n_prev      = ASCII_NUL;
            n_have      = 1'b0;
            n_neg       = 1'b0;
        end
        bundle.cnt_m1 = cnt[SLOT_W-1:0] - SLOT_W'(1);
    end

    assign o_push   = accept && (cnt != 3'd0);
    assign o_bundle = bundle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= ASCII_NUL;
            r_have <= 1'b0;
            r_neg  <= 1'b0;
        end else if (accept) begin
            r_prev <= n_prev;
            r_have <= n_have;
            r_neg  <= n_neg;
        end
    end

    // An open unary minus always follows a kept minus or digit
    a_neg_prev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_neg |-> (r_have && (r_prev == ASCII_MINUS || is_digit(r_prev))))
        else $error("unary minus open without minus or digit before it");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in_data.last) |=> (!r_have && !r_neg))
        else $error("state not cleared after final character");

    a_last_pushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in_data.last) |-> o_push)
        else $error("final character produced no result");

endmodule

// ===== hw/rtl/ien_queue.sv =====
`timescale 1ns / 1ps

module ien_queue #(
    parameter int DEPTH = ien_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  ien_pkg::t_bundle i_bundle,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_nonempty,
    output ien_pkg::t_bundle o_head
);
    import ien_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_bundle            r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    assign o_full     = (r_count == CNT_W'(DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_head     = r_mem[r_rd_ptr];

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= wrap_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= wrap_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_nonempty)
        else $error("pop from empty queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count out of range");

endmodule

// ===== hw/rtl/ien_back.sv =====
`timescale 1ns / 1ps

module ien_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_nonempty,
    input  ien_pkg::t_bundle   i_head,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ien_pkg::t_out_item o_out_data
);
    import ien_pkg::*;

    logic [SLOT_W-1:0] r_idx;
    logic              r_valid;
    t_out_item         r_out;
    logic              load;
    logic              at_end;

    assign load   = i_q_nonempty && (!r_valid || i_out_ready);
    assign at_end = (r_idx == i_head.cnt_m1);
    assign o_pop  = load && at_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= at_end ? '0 : r_idx + SLOT_W'(1);
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out.out_ch   <= i_head.chars[r_idx];
            r_out.out_last <= i_head.last && at_end;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_out;

    // Slot index never runs past the head bundle while it is pending
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_nonempty |-> (r_idx <= i_head.cnt_m1))
        else $error("slot index beyond bundle");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_out_ready) |=> (r_valid && $stable(r_out)))
        else $error("stalled result changed");

    a_idx_rewinds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_idx == '0))
        else $error("slot index not rewound after pop");

endmodule

// ===== hw/rtl/infix_expression_normalizer_core.sv =====
`timescale 1ns / 1ps

// Normalizes an infix expression fed one character per transaction: drops
// whitespace, inserts '*' between ')' and a following '(', and rewrites a
// unary minus as "(0-" plus its digits and a closing ')'. Each input
// transaction yields zero to four output transactions; the one marked
// out_last ends the expression (out_ch is 0 when that result only ends an
// empty tail). The front part classifies a character in the cycle it is
// accepted and pushes its whole expansion into a short queue; the back part
// drains that queue one result per cycle through a registered output while
// that output is taken. With the output taken, an input is taken every cycle
// while each character gives at most one result; a character that expands
// to several results is sent one result at a time, so sustained throughput
// is one result per cycle, set by the single output register. On acceptance
// the expansion is written into the queue; the back part then loads its first
// result into the output register, where it can be taken.
module infix_expression_normalizer_core #(
    parameter int QUEUE_DEPTH = ien_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ien_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ien_pkg::t_out_item o_out_data
);
    import ien_pkg::*;

    logic    q_full;
    logic    q_push;
    logic    q_pop;
    logic    q_nonempty;
    t_bundle push_bundle;
    t_bundle head_bundle;

    // Classify each character and track the expression state
    ien_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_bundle   (push_bundle)
    );

    // Hold expansions so each side can stall independently
    ien_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_bundle   (push_bundle),
        .o_full     (q_full),
        .i_pop      (q_pop),
        .o_nonempty (q_nonempty),
        .o_head     (head_bundle)
    );

    // Serialize one result per cycle into the output register while the output is not stalled
    ien_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_nonempty (q_nonempty),
        .i_head       (head_bundle),
        .o_pop        (q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    import ien_pkg::*;

    localparam logic [7:0] PLUS_CH  = 8'h2B;
    localparam logic [7:0] SLASH_CH = 8'h2F;

    // One character to send; hold_off makes the driver wait for an empty
    // result queue before it offers this character.
    typedef struct {
        t_in_item item;
        bit       hold_off;
    } t_char_entry;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_data   = '0;
    logic      i_out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out_data;

    t_char_entry char_q[$];
    t_out_item   normalized_q[$];
    t_out_item   head_item;
    logic        in_fire  = 1'b0;
    int          sent_cnt = 0;
    int          err_cnt  = 0;
    logic        calm;

    // Predictor state for the expression in progress
    logic [7:0]  last_kept  = 8'h00;
    logic        seen_kept  = 1'b0;
    logic        minus_open = 1'b0;

    infix_expression_normalizer_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Stretch with no idling on either side
    assign calm = (sent_cnt >= 120) && (sent_cnt < 180);

    function automatic logic is_numeral(input logic [7:0] c);
        return (c >= ASCII_ZERO) && (c <= ASCII_NINE);
    endfunction

    // Expand one accepted character into the normalized characters it yields
    function automatic void expand_char(input t_in_item it);
        logic [7:0] emit[$];
        logic       star;
        star = seen_kept && (last_kept == ASCII_RPAREN) && (it.ch == ASCII_LPAREN);
        if (!(it.ch == ASCII_SPACE || (it.ch >= ASCII_TAB && it.ch <= ASCII_CR))) begin
            // close an open negative number before any non-digit
            if (minus_open && !is_numeral(it.ch)) begin
                emit.push_back(ASCII_RPAREN);
                last_kept  = ASCII_RPAREN;
                minus_open = 1'b0;
            end
            if (star) begin
                emit.push_back(ASCII_STAR);
            end
            if (it.ch == ASCII_MINUS &&
                (!seen_kept || (last_kept != ASCII_RPAREN && !is_numeral(last_kept)))) begin
                emit.push_back(ASCII_LPAREN);
                emit.push_back(ASCII_ZERO);
                emit.push_back(ASCII_MINUS);
                last_kept  = ASCII_MINUS;
                minus_open = 1'b1;
            end else begin
                emit.push_back(it.ch);
                last_kept = it.ch;
            end
            seen_kept = 1'b1;
        end
        if (it.last) begin
            if (minus_open) begin
                emit.push_back(ASCII_RPAREN);
            end
            if (emit.size() == 0) begin
                emit.push_back(ASCII_NUL);
            end
            last_kept  = 8'h00;
            seen_kept  = 1'b0;
            minus_open = 1'b0;
        end
        foreach (emit[k]) begin
            normalized_q.push_back(t_out_item'{emit[k], it.last && (k == emit.size() - 1)});
        end
    endfunction

    task automatic queue_char(input logic [7:0] c, input logic lst, input bit hold);
        t_char_entry e;
        e.item.ch   = c;
        e.item.last = lst;
        e.hold_off  = hold;
        char_q.push_back(e);
    endtask

    task automatic queue_text(input string s, input bit hold);
        for (int k = 0; k < s.len(); k++) begin
            queue_char(s[k], k == s.len() - 1, hold && k == 0);
        end
    endtask

    initial begin : stimulus
        int         rand_cnt;
        int         len;
        int         r;
        bit         hold;
        logic [7:0] c;
        rand_cnt = 0;
        // Directed: unary minus at start and before an operator
        queue_text("-7+", 1'b0);
        // inserted '*' between ')' and '('
        queue_text("1)(2", 1'b0);
        // unary minus after an operator, closed at the end of input
        queue_text("2*-3", 1'b0);
        // unary minus with no digits
        queue_text("-", 1'b0);
        // whitespace joins digits; ending on whitespace gives an empty tail
        queue_text("4 5 ", 1'b0);
        // ending on whitespace with an open negative number
        queue_text("-\t", 1'b0);
        queue_text(" ", 1'b0);
        // minus after an open minus closes it and is kept as a binary minus
        queue_text("--", 1'b0);
        // extreme codes kept as ordinary characters
        queue_char(8'h00, 1'b0, 1'b0);
        queue_char(8'hFF, 1'b1, 1'b0);

        // Random expressions, mostly well formed, with some noise bytes
        while (rand_cnt < 250) begin
            len  = $urandom_range(1, 12);
            hold = (rand_cnt == 0) || ($urandom_range(0, 14) == 0);
            for (int k = 0; k < len; k++) begin
                r = $urandom_range(0, 99);
                if (r < 35) begin
                    c = ASCII_ZERO + 8'($urandom_range(0, 9));
                end else if (r < 50) begin
                    c = ASCII_MINUS;
                end else if (r < 60) begin
                    case ($urandom_range(0, 2))
                        0: c = PLUS_CH;
                        1: c = ASCII_STAR;
                        default: c = SLASH_CH;
                    endcase
                end else if (r < 75) begin
                    c = $urandom_range(0, 1) ? ASCII_LPAREN : ASCII_RPAREN;
                end else if (r < 87) begin
                    c = ($urandom_range(0, 5) == 5) ? ASCII_SPACE
                                                    : ASCII_TAB + 8'($urandom_range(0, 4));
                end else begin
                    c = 8'($urandom_range(0, 255));
                end
                queue_char(c, k == len - 1, hold && k == 0);
            end
            rand_cnt += len;
        end
    end

    // Driver: change inputs at the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= calm || ($urandom_range(0, 99) >= 25);
            if (!i_in_valid || in_fire) begin
                // hold a marked character until every result has drained
                if (char_q.size() != 0 &&
                    !(char_q[0].hold_off && normalized_q.size() != 0) &&
                    (calm || $urandom_range(0, 99) >= 25)) begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= char_q[0].item;
                    char_q.pop_front();
                    sent_cnt++;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: sample both channels at the rising edge
    always @(posedge i_clk) begin
        in_fire <= i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (normalized_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10) begin
                        $display("unexpected transaction: out_ch=%h out_last=%b",
                                 o_out_data.out_ch, o_out_data.out_last);
                    end
                end else begin
                    head_item = normalized_q.pop_front();
                    if (o_out_data.out_ch !== head_item.out_ch ||
                        o_out_data.out_last !== head_item.out_last) begin
                        err_cnt++;
                        if (err_cnt <= 10) begin
                            $display("mismatch: out_ch exp %h got %h, out_last exp %b got %b",
                                     head_item.out_ch, o_out_data.out_ch,
                                     head_item.out_last, o_out_data.out_last);
                        end
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                expand_char(i_in_data);
            end
        end
    end

    initial begin : finish_run
        @(posedge i_rst_n);
        while (char_q.size() != 0 || i_in_valid || normalized_q.size() != 0) begin
            @(posedge i_clk);
        end
        // let any stray result show up
        repeat (20) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin : watchdog
        #200000;
        $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/ien_pkg.sv
hw/rtl/ien_front.sv
hw/rtl/ien_queue.sv
hw/rtl/ien_back.sv
hw/rtl/infix_expression_normalizer_core.sv
sim/testbench.sv
